/* design/tap_changer_contactor_sequencer_defines.svh */
// Assertion macros used by the verification checker of the tap changer sequencer.
// No dependencies; include by bare file name.
`ifndef TAP_CHANGER_CONTACTOR_SEQUENCER_DEFINES_SVH
`define TAP_CHANGER_CONTACTOR_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define TCS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define TCS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/tcs_pkg.sv */
// Shared types, codes, reset values and the step table of the tap changer sequencer.
// No dependencies.
package tcs_pkg;

    localparam int MAX_LEVEL_DFLT  = 4;
    localparam int NUM_PHASES_DFLT = 3;

    localparam int ST_W    = 5;
    localparam int LVL_W   = 4;
    localparam int RELAY_N = 9;
    localparam int RLY_W   = 4;
    localparam int WAIT_W  = 16;
    localparam int VOLT_W  = 13;
    localparam int STEP_W  = 10;
    localparam int CIDX_W  = 3;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_SMALL_WAIT = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_BIG_WAIT   = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_BAND_LOW   = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_BAND_HIGH  = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_CUTOFF     = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_STEP       = 3'd5;

    localparam logic [WAIT_W-1:0] SMALL_WAIT_RST = 16'd100;
    localparam logic [WAIT_W-1:0] BIG_WAIT_RST   = 16'd5000;
    localparam logic [VOLT_W-1:0] BAND_LOW_RST   = 13'd2200;
    localparam logic [VOLT_W-1:0] BAND_HIGH_RST  = 13'd2400;
    localparam logic [VOLT_W-1:0] CUTOFF_RST     = 13'd1605;
    localparam logic [STEP_W-1:0] STEP_RST       = 10'd100;

    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    // sequencer state codes
    localparam logic [ST_W-1:0] S_IDLE  = 5'd0;
    localparam logic [ST_W-1:0] S_EN1   = 5'd1;
    localparam logic [ST_W-1:0] S_EN2   = 5'd2;
    localparam logic [ST_W-1:0] S_EN3   = 5'd3;
    localparam logic [ST_W-1:0] S_EN4   = 5'd4;
    localparam logic [ST_W-1:0] S_EN5   = 5'd5;
    localparam logic [ST_W-1:0] S_EN6   = 5'd6;
    localparam logic [ST_W-1:0] S_DIS1  = 5'd7;
    localparam logic [ST_W-1:0] S_DIS2  = 5'd8;
    localparam logic [ST_W-1:0] S_DIS3  = 5'd9;
    localparam logic [ST_W-1:0] S_DIS4  = 5'd10;
    localparam logic [ST_W-1:0] S_L4A   = 5'd11;
    localparam logic [ST_W-1:0] S_L4B   = 5'd12;
    localparam logic [ST_W-1:0] S_L3A   = 5'd13;
    localparam logic [ST_W-1:0] S_L3B   = 5'd14;
    localparam logic [ST_W-1:0] S_L2A   = 5'd15;
    localparam logic [ST_W-1:0] S_L2B   = 5'd16;
    localparam logic [ST_W-1:0] S_L1A   = 5'd17;
    localparam logic [ST_W-1:0] S_L1B   = 5'd18;
    localparam logic [ST_W-1:0] S_POL   = 5'd19;
    localparam logic [ST_W-1:0] S_EX1   = 5'd20;
    localparam logic [ST_W-1:0] S_EX2   = 5'd21;
    localparam logic [ST_W-1:0] S_EX3   = 5'd22;
    localparam logic [ST_W-1:0] S_EX4   = 5'd23;
    localparam logic [ST_W-1:0] S_EX5   = 5'd24;
    localparam logic [ST_W-1:0] S_EX6   = 5'd25;
    localparam logic [ST_W-1:0] S_END   = 5'd26;
    localparam logic [ST_W-1:0] S_COUNT = 5'd27;

    // step kinds
    localparam logic [1:0] K_RELAY   = 2'd0;
    localparam logic [1:0] K_BIG     = 2'd1;
    localparam logic [1:0] K_IDLE    = 2'd2;
    localparam logic [1:0] K_SPECIAL = 2'd3;

    // timer actions
    localparam logic [1:0] TMR_KEEP  = 2'd0;
    localparam logic [1:0] TMR_SMALL = 2'd1;
    localparam logic [1:0] TMR_BIG   = 2'd2;

    // relay numbers
    localparam logic [RLY_W-1:0] RLY_NONE = 4'd0;
    localparam logic [RLY_W-1:0] RLY_1    = 4'd1;
    localparam logic [RLY_W-1:0] RLY_2    = 4'd2;
    localparam logic [RLY_W-1:0] RLY_3    = 4'd3;
    localparam logic [RLY_W-1:0] RLY_5    = 4'd5;
    localparam logic [RLY_W-1:0] RLY_6    = 4'd6;
    localparam logic [RLY_W-1:0] RLY_7    = 4'd7;
    localparam logic [RLY_W-1:0] RLY_8    = 4'd8;
    localparam logic [RLY_W-1:0] RLY_9    = 4'd9;

    typedef struct packed {
        logic [1:0]      kind;
        logic [RLY_W-1:0] relay;
        logic            on;
        logic [ST_W-1:0] next;
    } step_t;

    typedef struct packed {
        logic [ST_W-1:0]         state;
        logic signed [LVL_W-1:0] level;
        logic [RELAY_N-1:0]      relays;
    } ent_t;

    typedef struct packed {
        logic                    change;
        logic signed [LVL_W-1:0] level;
    } lvl_calc_t;

    typedef struct packed {
        logic [ST_W-1:0]         state;
        logic signed [LVL_W-1:0] level;
        logic                    cmd;
        logic [RLY_W-1:0]        relay;
        logic                    on;
        logic [1:0]              tmr;
    } seq_out_t;

    function automatic step_t step_lookup(input logic [ST_W-1:0] st);
        step_t s;
        s = '{kind: K_SPECIAL, relay: RLY_NONE, on: 1'b0, next: S_IDLE};
        case (st)
            S_EN1:   s = '{kind: K_RELAY, relay: RLY_3, on: 1'b1, next: S_EN2};
            S_EN2:   s = '{kind: K_RELAY, relay: RLY_1, on: 1'b0, next: S_EN3};
            S_EN3:   s = '{kind: K_RELAY, relay: RLY_2, on: 1'b0, next: S_EN4};
            S_EN4:   s = '{kind: K_BIG,   relay: RLY_NONE, on: 1'b0, next: S_EN5};
            S_EN5:   s = '{kind: K_RELAY, relay: RLY_3, on: 1'b0, next: S_EN6};
            S_DIS1:  s = '{kind: K_RELAY, relay: RLY_6, on: 1'b0, next: S_DIS2};
            S_DIS2:  s = '{kind: K_RELAY, relay: RLY_7, on: 1'b0, next: S_DIS3};
            S_DIS3:  s = '{kind: K_RELAY, relay: RLY_8, on: 1'b0, next: S_DIS4};
            S_DIS4:  s = '{kind: K_IDLE,  relay: RLY_NONE, on: 1'b0, next: S_IDLE};
            S_L4A:   s = '{kind: K_RELAY, relay: RLY_7, on: 1'b1, next: S_L4B};
            S_L4B:   s = '{kind: K_RELAY, relay: RLY_8, on: 1'b1, next: S_POL};
            S_L3A:   s = '{kind: K_RELAY, relay: RLY_7, on: 1'b1, next: S_L3B};
            S_L3B:   s = '{kind: K_RELAY, relay: RLY_8, on: 1'b1, next: S_POL};
            S_L2A:   s = '{kind: K_RELAY, relay: RLY_7, on: 1'b1, next: S_L2B};
            S_L2B:   s = '{kind: K_RELAY, relay: RLY_8, on: 1'b1, next: S_POL};
            S_L1A:   s = '{kind: K_RELAY, relay: RLY_7, on: 1'b0, next: S_L1B};
            S_L1B:   s = '{kind: K_RELAY, relay: RLY_8, on: 1'b0, next: S_POL};
            S_EX1:   s = '{kind: K_RELAY, relay: RLY_2, on: 1'b1, next: S_EX2};
            S_EX2:   s = '{kind: K_RELAY, relay: RLY_3, on: 1'b1, next: S_EX3};
            S_EX3:   s = '{kind: K_RELAY, relay: RLY_1, on: 1'b1, next: S_EX4};
            S_EX4:   s = '{kind: K_RELAY, relay: RLY_2, on: 1'b0, next: S_EX5};
            S_EX5:   s = '{kind: K_BIG,   relay: RLY_NONE, on: 1'b0, next: S_EX6};
            S_EX6:   s = '{kind: K_RELAY, relay: RLY_3, on: 1'b0, next: S_END};
            S_END:   s = '{kind: K_IDLE,  relay: RLY_NONE, on: 1'b0, next: S_IDLE};
            default: s = '{kind: K_SPECIAL, relay: RLY_NONE, on: 1'b0, next: S_IDLE};
        endcase
        return s;
    endfunction

endpackage

/* design/tcs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/tcs_level_calc.sv */
// Tap level choice for an idle phase: cutoff test, band test and clamped step count.
// Depends on tcs_pkg.
module tcs_level_calc #(
    parameter int MAX_LEVEL = tcs_pkg::MAX_LEVEL_DFLT
) (
    input  logic signed [tcs_pkg::LVL_W-1:0]  cur_level,
    input  logic [tcs_pkg::VOLT_W-1:0]        voltage,
    input  logic [tcs_pkg::VOLT_W-1:0]        band_low,
    input  logic [tcs_pkg::VOLT_W-1:0]        band_high,
    input  logic [tcs_pkg::VOLT_W-1:0]        cutoff,
    input  logic [tcs_pkg::STEP_W-1:0]        step,
    output tcs_pkg::lvl_calc_t                result
);

    // quotient only matters up to the span of the clamp window
    localparam int QMAX = 2 * MAX_LEVEL;
    localparam int QW   = $clog2(QMAX + 2);
    localparam int THW  = tcs_pkg::STEP_W + 4;
    localparam int SW   = 6;
    localparam int PW   = 15;

    logic [tcs_pkg::STEP_W-1:0]  step_eff;
    logic signed [PW-1:0]        lvl_prod;
    logic signed [15:0]          vin;
    logic                        low_cut;
    logic                        below;
    logic                        above;
    logic [tcs_pkg::VOLT_W-1:0]  delta;
    logic [QMAX-1:0]             ge;
    logic [QW-1:0]               quot;
    logic [QW-1:0]               n_steps;
    logic signed [SW-1:0]        sum;
    logic signed [SW-1:0]        lim_hi;
    logic signed [SW-1:0]        lim_lo;
    logic signed [tcs_pkg::LVL_W-1:0] clamped;

    always_comb
    begin
        step_eff = (step == '0) ? tcs_pkg::STEP_W'(1) : step;
        lvl_prod = $signed({{(PW-tcs_pkg::LVL_W){cur_level[tcs_pkg::LVL_W-1]}}, cur_level})
                 * $signed({{(PW-tcs_pkg::STEP_W){1'b0}}, step_eff});
        vin      = $signed({3'b000, voltage}) + 16'(lvl_prod);
        low_cut  = vin < $signed({3'b000, cutoff});
        below    = voltage < band_low;
        above    = voltage > band_high;
        delta    = below ? (band_low - voltage) : (voltage - band_high);

        // thermometer of delta >= k*step, counted to a saturated quotient
        for (int k = 1; k <= QMAX; k++)
        begin
            ge[k-1] = {1'b0, delta} >= (THW'(k) * THW'(step_eff));
        end
        quot    = QW'($countones(ge));
        n_steps = quot + QW'(1);

        lim_hi = SW'(MAX_LEVEL);
        lim_lo = -lim_hi;
        if (below)
        begin
            sum = SW'(cur_level) - $signed({{(SW-QW){1'b0}}, n_steps});
        end
        else
        begin
            sum = SW'(cur_level) + $signed({{(SW-QW){1'b0}}, n_steps});
        end
        if (sum > lim_hi)
        begin
            clamped = tcs_pkg::LVL_W'(lim_hi);
        end
        else if (sum < lim_lo)
        begin
            clamped = tcs_pkg::LVL_W'(lim_lo);
        end
        else
        begin
            clamped = tcs_pkg::LVL_W'(sum);
        end

        result.change = low_cut || below || above;
        result.level  = low_cut ? '0 : clamped;
    end

endmodule

/* design/tcs_seq_step.sv */
// One step of a phase's relay sequencer: next state, relay command and timer action.
// Depends on tcs_pkg.
module tcs_seq_step (
    input  logic [tcs_pkg::ST_W-1:0]          state,
    input  logic signed [tcs_pkg::LVL_W-1:0]  level,
    input  logic                              timer_zero,
    input  logic                              good,
    input  tcs_pkg::lvl_calc_t                calc,
    output tcs_pkg::seq_out_t                 result
);

    tcs_pkg::step_t            st_info;
    logic [tcs_pkg::LVL_W-1:0] mag;

    always_comb
    begin
        st_info = tcs_pkg::step_lookup(state);
        mag     = level[tcs_pkg::LVL_W-1] ? (-level) : level;

        result.state = state;
        result.level = level;
        result.cmd   = 1'b0;
        result.relay = tcs_pkg::RLY_NONE;
        result.on    = 1'b0;
        result.tmr   = tcs_pkg::TMR_KEEP;

        if (state >= tcs_pkg::S_COUNT)
        begin
            result.state = tcs_pkg::S_IDLE;
        end
        else if (state == tcs_pkg::S_IDLE)
        begin
            if (good && calc.change && (calc.level != level))
            begin
                result.level = calc.level;
                result.cmd   = 1'b1;
                result.relay = tcs_pkg::RLY_2;
                result.on    = 1'b1;
                result.state = tcs_pkg::S_EN1;
            end
        end
        else if (timer_zero)
        begin
            if (state == tcs_pkg::S_EN6)
            begin
                // stage decision by level magnitude
                result.cmd   = 1'b1;
                result.relay = tcs_pkg::RLY_6;
                case (mag)
                    4'd0:
                    begin
                        result.relay = tcs_pkg::RLY_5;
                        result.state = tcs_pkg::S_DIS1;
                    end
                    4'd4:
                    begin
                        result.on    = 1'b1;
                        result.state = tcs_pkg::S_L4A;
                    end
                    4'd3:
                    begin
                        result.on    = 1'b1;
                        result.state = tcs_pkg::S_L3A;
                    end
                    4'd2:    result.state = tcs_pkg::S_L2A;
                    4'd1:    result.state = tcs_pkg::S_L1A;
                    default:
                    begin
                        result.cmd   = 1'b0;
                        result.relay = tcs_pkg::RLY_NONE;
                        result.state = tcs_pkg::S_POL;
                    end
                endcase
            end
            else if (state == tcs_pkg::S_POL)
            begin
                result.cmd   = 1'b1;
                result.relay = tcs_pkg::RLY_9;
                result.on    = (level > 0);
                result.state = tcs_pkg::S_EX1;
            end
            else
            begin
                case (st_info.kind)
                    tcs_pkg::K_RELAY:
                    begin
                        result.cmd   = 1'b1;
                        result.relay = st_info.relay;
                        result.on    = st_info.on;
                        result.state = st_info.next;
                    end
                    tcs_pkg::K_BIG:
                    begin
                        result.tmr   = tcs_pkg::TMR_BIG;
                        result.state = st_info.next;
                    end
                    default: result.state = tcs_pkg::S_IDLE;
                endcase
            end
        end

        if (result.cmd)
        begin
            result.tmr = tcs_pkg::TMR_SMALL;
        end
    end

endmodule

/* design/tap_changer_contactor_sequencer.sv */
// Three-phase tap changer contactor sequencer, top level.
// One read-modify-write of the phase memory per item; its result goes to the output register.
// Throughput: one item per cycle, unless a result waits on a full output register.
// Reset (rst_n low, async): clear pipeline, timers, valid bits; load register defaults.
// Phase memory needs no clearing pass: an entry never written reads as idle/level 0/off.
// Depends on tcs_pkg, tcs_ram, tcs_level_calc, tcs_seq_step.
module tap_changer_contactor_sequencer #(
    parameter int MAX_LEVEL  = tcs_pkg::MAX_LEVEL_DFLT,
    parameter int NUM_PHASES = tcs_pkg::NUM_PHASES_DFLT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // request channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               req_type,
    input  logic [1:0]                         phase_sel,
    input  logic [tcs_pkg::VOLT_W-1:0]         voltage_dv,
    input  logic                               measure_good,
    // result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         out_phase,
    output logic                               relay_valid,
    output logic [tcs_pkg::RLY_W-1:0]          relay_number,
    output logic                               relay_on,
    output logic [tcs_pkg::RELAY_N-1:0]        relay_mask,
    output logic                               busy_res,
    output logic signed [tcs_pkg::LVL_W-1:0]   tap_level,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tcs_pkg::CIDX_W-1:0]         cfg_index,
    input  logic [tcs_pkg::WAIT_W-1:0]         cfg_data
);

    localparam int AW    = (NUM_PHASES > 1) ? $clog2(NUM_PHASES) : 1;
    localparam int ENT_W = $bits(tcs_pkg::ent_t);

    // ---------------------------------------------------------------
    // Configuration registers, always ready. User must write only while idle; not enforced.
    // ---------------------------------------------------------------
    logic [tcs_pkg::WAIT_W-1:0] small_wait_reg;
    logic [tcs_pkg::WAIT_W-1:0] big_wait_reg;
    logic [tcs_pkg::VOLT_W-1:0] band_low_reg;
    logic [tcs_pkg::VOLT_W-1:0] band_high_reg;
    logic [tcs_pkg::VOLT_W-1:0] cutoff_reg;
    logic [tcs_pkg::STEP_W-1:0] step_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            small_wait_reg <= tcs_pkg::SMALL_WAIT_RST;
            big_wait_reg   <= tcs_pkg::BIG_WAIT_RST;
            band_low_reg   <= tcs_pkg::BAND_LOW_RST;
            band_high_reg  <= tcs_pkg::BAND_HIGH_RST;
            cutoff_reg     <= tcs_pkg::CUTOFF_RST;
            step_reg       <= tcs_pkg::STEP_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tcs_pkg::CFG_SMALL_WAIT: small_wait_reg <= cfg_data;
                tcs_pkg::CFG_BIG_WAIT:   big_wait_reg   <= cfg_data;
                tcs_pkg::CFG_BAND_LOW:   band_low_reg   <= cfg_data[tcs_pkg::VOLT_W-1:0];
                tcs_pkg::CFG_BAND_HIGH:  band_high_reg  <= cfg_data[tcs_pkg::VOLT_W-1:0];
                tcs_pkg::CFG_CUTOFF:     cutoff_reg     <= cfg_data[tcs_pkg::VOLT_W-1:0];
                tcs_pkg::CFG_STEP:       step_reg       <= cfg_data[tcs_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Accept stage: each accepted in-range request issues the read of its phase entry.
    // ---------------------------------------------------------------
    logic                in_fire;
    logic                in_range;
    logic [AW-1:0]       rd_addr;

    // Stage 1: the entry is back from memory; compute and write back.
    logic                s1_valid_reg;
    logic                s1_type_reg;
    logic [1:0]          s1_phase_reg;
    logic                s1_inr_reg;
    logic [tcs_pkg::VOLT_W-1:0] s1_volt_reg;
    logic                s1_good_reg;
    logic                rd_vld_reg;
    logic                fwd_hit_reg;
    tcs_pkg::ent_t       fwd_data_reg;
    logic                s1_fire;
    logic                s1_result;
    logic [AW-1:0]       s1_addr;

    logic                wr_en;
    tcs_pkg::ent_t       wr_ent;
    logic [ENT_W-1:0]    ram_rd_data;
    tcs_pkg::ent_t       cur_ent;

    logic [NUM_PHASES-1:0]      ent_valid_reg;
    logic [NUM_PHASES-1:0]      ent_valid_next;
    logic [tcs_pkg::WAIT_W-1:0] timer_reg  [NUM_PHASES];
    logic [tcs_pkg::WAIT_W-1:0] timer_next [NUM_PHASES];
    logic                       timer_zero;

    tcs_pkg::lvl_calc_t         calc;
    tcs_pkg::seq_out_t          seq;
    logic [tcs_pkg::RELAY_N-1:0] new_mask;

    // Output register
    logic                       out_valid_reg;
    logic [1:0]                 out_phase_reg;
    logic                       relay_valid_reg;
    logic [tcs_pkg::RLY_W-1:0]  relay_number_reg;
    logic                       relay_on_reg;
    logic [tcs_pkg::RELAY_N-1:0] relay_mask_reg;
    logic                       busy_res_reg;
    logic signed [tcs_pkg::LVL_W-1:0] tap_level_reg;
    logic                       out_free;

    assign in_range = ({1'b0, phase_sel} < 3'(NUM_PHASES));
    assign rd_addr  = phase_sel[AW-1:0];
    assign out_free = !out_valid_reg || out_ready;

    // Stage 1 moves on unless it holds a result and the output register is full.
    assign s1_result = s1_valid_reg && (s1_type_reg == tcs_pkg::REQ_UPDATE) && s1_inr_reg;
    assign s1_fire   = s1_valid_reg && (!s1_result || out_free);
    assign in_ready  = !s1_valid_reg || s1_fire;
    assign in_fire   = in_valid && in_ready;
    assign s1_addr   = s1_phase_reg[AW-1:0];

    assign wr_en  = s1_fire && s1_result;
    assign wr_ent = '{state: seq.state, level: seq.level, relays: new_mask};

    tcs_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_PHASES)
    ) u_phase_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_addr),
        .wr_data (wr_ent),
        .rd_en   (in_fire && in_range),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Capture the item and, when the previous item writes the same phase at this
    // very edge, take its write data instead of the stale memory read.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_type_reg  <= req_type;
            s1_phase_reg <= phase_sel;
            s1_inr_reg   <= in_range;
            s1_volt_reg  <= voltage_dv;
            s1_good_reg  <= measure_good;
            rd_vld_reg   <= in_range ? ent_valid_reg[rd_addr] : 1'b0;
            fwd_hit_reg  <= wr_en && in_range && (s1_addr == rd_addr);
            fwd_data_reg <= wr_ent;
        end
    end

    always_comb
    begin
        if (fwd_hit_reg)
        begin
            cur_ent = fwd_data_reg;
        end
        else if (rd_vld_reg)
        begin
            cur_ent = tcs_pkg::ent_t'(ram_rd_data);
        end
        else
        begin
            cur_ent = '0;
        end
    end

    assign timer_zero = (timer_reg[s1_addr] == '0);

    tcs_level_calc #(
        .MAX_LEVEL (MAX_LEVEL)
    ) u_level_calc (
        .cur_level (cur_ent.level),
        .voltage   (s1_volt_reg),
        .band_low  (band_low_reg),
        .band_high (band_high_reg),
        .cutoff    (cutoff_reg),
        .step      (step_reg),
        .result    (calc)
    );

    tcs_seq_step u_seq_step (
        .state      (cur_ent.state),
        .level      (cur_ent.level),
        .timer_zero (timer_zero),
        .good       (s1_good_reg),
        .calc       (calc),
        .result     (seq)
    );

    // Drive the commanded relay bit; leave the others.
    always_comb
    begin
        for (int i = 0; i < tcs_pkg::RELAY_N; i++)
        begin
            if (seq.cmd && (seq.relay == tcs_pkg::RLY_W'(i + 1)))
            begin
                new_mask[i] = seq.on;
            end
            else
            begin
                new_mask[i] = cur_ent.relays[i];
            end
        end
    end

    // Timers: a tick counts every running timer down; an update may restart its own.
    always_comb
    begin
        ent_valid_next = ent_valid_reg;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            timer_next[p] = timer_reg[p];
        end
        if (s1_fire && s1_valid_reg && (s1_type_reg == tcs_pkg::REQ_TICK))
        begin
            for (int p = 0; p < NUM_PHASES; p++)
            begin
                if (timer_reg[p] != '0)
                begin
                    timer_next[p] = timer_reg[p] - tcs_pkg::WAIT_W'(1);
                end
            end
        end
        else if (wr_en)
        begin
            ent_valid_next[s1_addr] = 1'b1;
            case (seq.tmr)
                tcs_pkg::TMR_SMALL: timer_next[s1_addr] = small_wait_reg;
                tcs_pkg::TMR_BIG:   timer_next[s1_addr] = big_wait_reg;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= '0;
            for (int p = 0; p < NUM_PHASES; p++)
            begin
                timer_reg[p] <= '0;
            end
        end
        else
        begin
            ent_valid_reg <= ent_valid_next;
            for (int p = 0; p < NUM_PHASES; p++)
            begin
                timer_reg[p] <= timer_next[p];
            end
        end
    end

    // ---------------------------------------------------------------
    // Output register: hold the result until taken.
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            out_phase_reg    <= s1_phase_reg;
            relay_valid_reg  <= seq.cmd;
            relay_number_reg <= seq.cmd ? seq.relay : tcs_pkg::RLY_NONE;
            relay_on_reg     <= seq.cmd && seq.on;
            relay_mask_reg   <= new_mask;
            busy_res_reg     <= (seq.state != tcs_pkg::S_IDLE);
            tap_level_reg    <= seq.level;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_phase    = out_phase_reg;
    assign relay_valid  = relay_valid_reg;
    assign relay_number = relay_number_reg;
    assign relay_on     = relay_on_reg;
    assign relay_mask   = relay_mask_reg;
    assign busy_res     = busy_res_reg;
    assign tap_level    = tap_level_reg;

endmodule

/* design/tcs_checker.sv */
// Port-level checks of the tap changer sequencer, bound to the top level.
// Depends on tcs_pkg and tap_changer_contactor_sequencer_defines.svh.
`include "tap_changer_contactor_sequencer_defines.svh"

module tcs_checker #(
    parameter int MAX_LEVEL  = tcs_pkg::MAX_LEVEL_DFLT,
    parameter int NUM_PHASES = tcs_pkg::NUM_PHASES_DFLT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [1:0]                        out_phase,
    input  logic                              relay_valid,
    input  logic [tcs_pkg::RLY_W-1:0]         relay_number,
    input  logic                              relay_on,
    input  logic [tcs_pkg::RELAY_N-1:0]       relay_mask,
    input  logic signed [tcs_pkg::LVL_W-1:0]  tap_level
);

    localparam logic signed [tcs_pkg::LVL_W-1:0] LVL_HI = tcs_pkg::LVL_W'(MAX_LEVEL);
    localparam logic signed [tcs_pkg::LVL_W-1:0] LVL_LO = -LVL_HI;

    // A stalled result holds its payload.
    `TCS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_phase) && $stable(relay_mask) && $stable(tap_level),
        "stalled result changed")

    // A reported command names a real relay and leaves the mask in that state.
    `TCS_ASSERT_IMP(a_relay_cmd, clk, rst_n, out_valid && relay_valid,
        relay_number >= 4'd1 && relay_number <= 4'd9 &&
        relay_mask[relay_number - 4'd1] == relay_on,
        "relay command inconsistent with mask")

    // No command means no relay number and no enable.
    `TCS_ASSERT_IMP(a_relay_idle, clk, rst_n, out_valid && !relay_valid,
        relay_number == 4'd0 && !relay_on, "idle result carries a relay command")

    // Level stays in the clamp window and the phase exists.
    `TCS_ASSERT_IMP(a_level_range, clk, rst_n, out_valid,
        tap_level <= LVL_HI && tap_level >= LVL_LO && {1'b0, out_phase} < 3'(NUM_PHASES),
        "level or phase out of range")

endmodule

bind tap_changer_contactor_sequencer tcs_checker #(
    .MAX_LEVEL  (MAX_LEVEL),
    .NUM_PHASES (NUM_PHASES)
) u_tcs_checker (.*);
